### src/rpmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpmt_pkg: shared definitions for the remap prefix match table
// Sizes, function codes, the packed slot record, the controller state type
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rpmt_pkg;

   localparam int ENTRIES = 32;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int ADDR_W  = 48;
   localparam int SLOT_W  = 6;
   localparam int HIT_W   = 5;
   localparam int LVL_W   = 2;
   localparam int FLD_W   = 9;
   localparam int LEN_W   = 3;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   localparam logic [LEN_W-1:0] LEN_NONE = LEN_W'(0);
   localparam logic [LEN_W-1:0] LEN_PDPT = LEN_W'(2);
   localparam logic [LEN_W-1:0] LEN_PD   = LEN_W'(3);
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(4);

   localparam logic [LVL_W-1:0] REUSE_PT = LVL_W'(3);

   typedef struct packed {
      logic [SLOT_W-1:0] pt_slot;
      logic              pd_large;
      logic [SLOT_W-1:0] pd_slot;
      logic              pdpt_large;
      logic [SLOT_W-1:0] pdpt_slot;
   } slot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_req;
      logic scan;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic done;
   } sts_type;

endpackage : rpmt_pkg
`default_nettype wire

### src/rpmt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpmt_ctrl: request sequencer
// Accepts a request, runs the datapath scan until it reports done, then
// moves the result into the output register when that register is free.
// ----------------------------------------------------------------------------
module rpmt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rpmt_pkg::cmd_type     cmd,
   input  wire rpmt_pkg::sts_type sts
);
   import rpmt_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The output register is free once its pending beat is taken.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : rpmt_ctrl
`default_nettype wire

### src/rpmt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpmt_dp: table storage and scan datapath
// Holds the entry memory and valid bits, reads one entry per cycle, compares
// its index fields to the request; keeps the best lookup hit, stores inserts.
// ----------------------------------------------------------------------------
module rpmt_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rpmt_pkg::cmd_type             cmd,
   output rpmt_pkg::sts_type                  sts,
   input  wire logic                          req_func,
   input  wire logic [rpmt_pkg::ADDR_W-1:0]   req_vaddr,
   input  wire logic [rpmt_pkg::SLOT_W-1:0]   req_new_pdpt_slot,
   input  wire logic                          req_new_pdpt_large,
   input  wire logic [rpmt_pkg::SLOT_W-1:0]   req_new_pd_slot,
   input  wire logic                          req_new_pd_large,
   input  wire logic [rpmt_pkg::SLOT_W-1:0]   req_new_pt_slot,
   output logic                               rsp_found,
   output logic [rpmt_pkg::LVL_W-1:0]         rsp_reuse_level,
   output logic [rpmt_pkg::HIT_W-1:0]         rsp_hit_index,
   output logic [rpmt_pkg::SLOT_W-1:0]        rsp_hit_pdpt_slot,
   output logic                               rsp_hit_pdpt_large,
   output logic [rpmt_pkg::SLOT_W-1:0]        rsp_hit_pd_slot,
   output logic                               rsp_hit_pd_large,
   output logic [rpmt_pkg::SLOT_W-1:0]        rsp_hit_pt_slot,
   output logic                               rsp_table_full
);
   import rpmt_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // Entry storage; an entry is empty while its valid bit is clear.
   logic [ADDR_W-1:0] addr_mem [ENTRIES];
   slot_type          slot_mem [ENTRIES];
   logic [ENTRIES-1:0] vld_ff;

   // Latched request.
   logic              func_ff;
   logic [ADDR_W-1:0] vaddr_ff;
   slot_type          new_slots_ff;

   // Read issue and compare stage.
   logic [IDX_W-1:0]  rd_cnt_ff;
   logic              issued_all_ff;
   logic              pv_ff;
   logic [IDX_W-1:0]  pidx_ff;
   logic              valid_q_ff;
   logic [ADDR_W-1:0] addr_q_ff;
   slot_type          slots_q_ff;
   logic              done_ff;

   // Best candidate.
   logic              have_ff;
   logic [LEN_W-1:0]  best_len_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   slot_type          best_slots_ff;
   logic              full_ff;

   // Output register payload.
   logic              found_ff;
   logic [LVL_W-1:0]  reuse_ff;
   logic [HIT_W-1:0]  hit_index_ff;
   slot_type          hit_slots_ff;
   logic              table_full_ff;

   logic              issue;
   logic              stage_act;
   logic [3:0]        fld_eq;
   logic [LEN_W-1:0]  len;
   logic              last;
   logic              is_ins;
   logic              hit;
   logic              early;
   logic              take;
   logic              wr_en;
   logic              full_set;
   logic              finish;

   always_comb begin
      issue     = cmd.scan && !issued_all_ff && !done_ff;
      stage_act = pv_ff && !done_ff;
      for (int k = 0; k < 4; k++) begin
         fld_eq[k] = addr_q_ff[ADDR_W-1-FLD_W*k -: FLD_W]
                     == vaddr_ff[ADDR_W-1-FLD_W*k -: FLD_W];
      end
      // Prefix length counts matching index fields from the pml4 end.
      if (!fld_eq[0]) begin
         len = LEN_NONE;
      end else if (!fld_eq[1]) begin
         len = LEN_W'(1);
      end else if (!fld_eq[2]) begin
         len = LEN_PDPT;
      end else if (!fld_eq[3]) begin
         len = LEN_PD;
      end else begin
         len = LEN_FULL;
      end
      last   = pidx_ff == LAST_IDX;
      is_ins = func_ff == FUNC_INSERT;
      hit    = valid_q_ff && (len != LEN_NONE);
      early  = hit && ((len >= LEN_PDPT && slots_q_ff.pdpt_large)
                    || (len >= LEN_PD && slots_q_ff.pd_large)
                    || (len == LEN_FULL));
      take   = early || (hit && (!have_ff || len > best_len_ff));
      wr_en    = stage_act && is_ins && !valid_q_ff;
      full_set = stage_act && is_ins && valid_q_ff && last;
      finish   = is_ins ? (!valid_q_ff || last) : (early || last);
      sts.done = done_ff;
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         addr_mem[pidx_ff] <= vaddr_ff;
         slot_mem[pidx_ff] <= new_slots_ff;
      end
      if (issue) begin
         addr_q_ff  <= addr_mem[rd_cnt_ff];
         slots_q_ff <= slot_mem[rd_cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rd_cnt_ff     <= '0;
         issued_all_ff <= 1'b0;
         pv_ff         <= 1'b0;
         done_ff       <= 1'b0;
         have_ff       <= 1'b0;
         full_ff       <= 1'b0;
      end else if (cmd.load_req) begin
         rd_cnt_ff     <= '0;
         issued_all_ff <= 1'b0;
         pv_ff         <= 1'b0;
         done_ff       <= 1'b0;
         have_ff       <= 1'b0;
         full_ff       <= 1'b0;
      end else begin
         if (issue) begin
            rd_cnt_ff     <= rd_cnt_ff + IDX_W'(1);
            issued_all_ff <= rd_cnt_ff == LAST_IDX;
            pv_ff         <= 1'b1;
         end else begin
            pv_ff <= 1'b0;
         end
         if (wr_en) begin
            // Inserting address zero leaves the entry empty.
            vld_ff[pidx_ff] <= vaddr_ff != '0;
         end
         if (stage_act) begin
            if (!is_ins && take) begin
               have_ff <= 1'b1;
            end
            if (finish) begin
               done_ff <= 1'b1;
            end
            if (full_set) begin
               full_ff <= 1'b1;
            end
         end
      end
   end

   // Payload registers without reset.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff                 <= req_func;
         vaddr_ff                <= req_vaddr;
         new_slots_ff.pdpt_slot  <= req_new_pdpt_slot;
         new_slots_ff.pdpt_large <= req_new_pdpt_large;
         new_slots_ff.pd_slot    <= req_new_pd_slot;
         new_slots_ff.pd_large   <= req_new_pd_large;
         new_slots_ff.pt_slot    <= req_new_pt_slot;
      end
      if (issue) begin
         pidx_ff    <= rd_cnt_ff;
         valid_q_ff <= vld_ff[rd_cnt_ff];
      end
      if (stage_act && !is_ins && take) begin
         best_len_ff   <= len;
         best_idx_ff   <= pidx_ff;
         best_slots_ff <= slots_q_ff;
      end
      if (cmd.load_rsp) begin
         found_ff      <= have_ff;
         table_full_ff <= full_ff;
         if (have_ff) begin
            reuse_ff     <= (best_len_ff >= LEN_PD) ? REUSE_PT : best_len_ff[LVL_W-1:0];
            hit_index_ff <= HIT_W'(best_idx_ff);
            hit_slots_ff <= best_slots_ff;
         end else begin
            reuse_ff     <= '0;
            hit_index_ff <= '0;
            hit_slots_ff <= '0;
         end
      end
   end

   assign rsp_found          = found_ff;
   assign rsp_reuse_level    = reuse_ff;
   assign rsp_hit_index      = hit_index_ff;
   assign rsp_hit_pdpt_slot  = hit_slots_ff.pdpt_slot;
   assign rsp_hit_pdpt_large = hit_slots_ff.pdpt_large;
   assign rsp_hit_pd_slot    = hit_slots_ff.pd_slot;
   assign rsp_hit_pd_large   = hit_slots_ff.pd_large;
   assign rsp_hit_pt_slot    = hit_slots_ff.pt_slot;
   assign rsp_table_full     = table_full_ff;

endmodule : rpmt_dp
`default_nettype wire

### src/remap_prefix_match_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// remap_prefix_match_table: table of remapped virtual addresses
// Keeps ENTRIES remapped addresses with their copied table slots, inserts
// new entries and finds the entry sharing the longest index prefix.
// ----------------------------------------------------------------------------
// The block handles one request beat at a time and answers every request
// with exactly one response beat. An insert (func 1) stores the address and
// slots in the first empty entry, or reports table_full when none is empty.
// A lookup (func 0) walks the entries in order and returns the one whose
// pml4, pdpt, pd and pt index fields match the longest prefix of the
// request address, the earliest entry winning a tie; it stops early on an
// entry whose match reaches a large-page level or covers all four fields
// and then returns that entry. The walk reads one entry per cycle from the
// entry memory through a registered read port, and an insert or a lookup
// that stops early ends the walk before the last entry. If the output
// register still holds an untaken beat, the finished walk waits until that
// beat is taken. The next request can be accepted in the cycle after the
// response is loaded. The response register holds a finished beat while
// the next request is accepted and scanned. Valid bits for all entries are
// cleared by reset, so the table is usable on the first cycle after reset.
// ----------------------------------------------------------------------------
module remap_prefix_match_table (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_func,
   input  wire logic [rpmt_pkg::ADDR_W-1:0] req_vaddr,
   input  wire logic [rpmt_pkg::SLOT_W-1:0] req_new_pdpt_slot,
   input  wire logic                        req_new_pdpt_large,
   input  wire logic [rpmt_pkg::SLOT_W-1:0] req_new_pd_slot,
   input  wire logic                        req_new_pd_large,
   input  wire logic [rpmt_pkg::SLOT_W-1:0] req_new_pt_slot,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_found,
   output logic [rpmt_pkg::LVL_W-1:0]       rsp_reuse_level,
   output logic [rpmt_pkg::HIT_W-1:0]       rsp_hit_index,
   output logic [rpmt_pkg::SLOT_W-1:0]      rsp_hit_pdpt_slot,
   output logic                             rsp_hit_pdpt_large,
   output logic [rpmt_pkg::SLOT_W-1:0]      rsp_hit_pd_slot,
   output logic                             rsp_hit_pd_large,
   output logic [rpmt_pkg::SLOT_W-1:0]      rsp_hit_pt_slot,
   output logic                             rsp_table_full
);
   import rpmt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // The controller sequences accept, scan and response load.
   rpmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath owns the entry memory, the compare stage and the
   // response payload register.
   rpmt_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_func           (req_func),
      .req_vaddr          (req_vaddr),
      .req_new_pdpt_slot  (req_new_pdpt_slot),
      .req_new_pdpt_large (req_new_pdpt_large),
      .req_new_pd_slot    (req_new_pd_slot),
      .req_new_pd_large   (req_new_pd_large),
      .req_new_pt_slot    (req_new_pt_slot),
      .rsp_found          (rsp_found),
      .rsp_reuse_level    (rsp_reuse_level),
      .rsp_hit_index      (rsp_hit_index),
      .rsp_hit_pdpt_slot  (rsp_hit_pdpt_slot),
      .rsp_hit_pdpt_large (rsp_hit_pdpt_large),
      .rsp_hit_pd_slot    (rsp_hit_pd_slot),
      .rsp_hit_pd_large   (rsp_hit_pd_large),
      .rsp_hit_pt_slot    (rsp_hit_pt_slot),
      .rsp_table_full     (rsp_table_full)
   );

endmodule : remap_prefix_match_table
`default_nettype wire
